FILE: design/ics_pkg.sv
`default_nettype none

package ics_pkg;

   // position and count counter width
   localparam int COUNT_WIDTH = 16;
   localparam int SUM_WIDTH   = 16;
   localparam int BYTE_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH = 2;
   // common width for comparing counters against 16-bit registers
   localparam int CMP_WIDTH = (COUNT_WIDTH > SUM_WIDTH) ? COUNT_WIDTH : SUM_WIDTH;

   localparam logic [SUM_WIDTH-1:0] SUM_MASK = 16'hFFFF;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_START_OFFSET = 2'd0,
      CSR_SUM_LENGTH   = 2'd1,
      CSR_PSEUDO_SUM   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic [SUM_WIDTH-1:0] checksum;
      logic [SUM_WIDTH-1:0] summed_bytes;
   } result_type;

   // one's-complement add with end-around carry
   function automatic logic [SUM_WIDTH-1:0] add_end_around(
      input logic [SUM_WIDTH-1:0] a,
      input logic [SUM_WIDTH-1:0] b
   );
      logic [SUM_WIDTH:0] raw;
      raw = {1'b0, a} + {1'b0, b};
      return raw[SUM_WIDTH-1:0] + {{(SUM_WIDTH-1){1'b0}}, raw[SUM_WIDTH]};
   endfunction

endpackage

`default_nettype wire

FILE: design/ics_accum.sv
`default_nettype none

module ics_accum import ics_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [BYTE_WIDTH-1:0]    data_byte,
   input  wire logic                     last_byte,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [SUM_WIDTH-1:0]     csr_data,
   output result_type                    result
);

   logic [SUM_WIDTH-1:0]   start_offset_ff;
   logic [SUM_WIDTH-1:0]   sum_length_ff;
   logic [SUM_WIDTH-1:0]   pseudo_sum_ff;
   logic [SUM_WIDTH-1:0]   running_sum_ff, running_sum_in;
   logic [COUNT_WIDTH-1:0] byte_position_ff, byte_position_in;
   logic [COUNT_WIDTH-1:0] included_count_ff, included_count_in;
   logic                   word_half_ff, word_half_in;

   logic                   include_byte;
   logic [SUM_WIDTH-1:0]   word;
   logic [SUM_WIDTH-1:0]   next_sum;
   logic [COUNT_WIDTH-1:0] next_count;

   // decide whether this beat is inside the summed window and form the next sum and count
   always_comb begin
      include_byte = (CMP_WIDTH'(byte_position_ff) >= CMP_WIDTH'(start_offset_ff)) &&
                     (CMP_WIDTH'(included_count_ff) < CMP_WIDTH'(sum_length_ff));
      word = word_half_ff ? {8'h00, data_byte} : {data_byte, 8'h00};
      next_sum = include_byte ? add_end_around(running_sum_ff, word) : running_sum_ff;
      next_count = (include_byte && (included_count_ff != {COUNT_WIDTH{1'b1}})) ?
                   included_count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : included_count_ff;
   end

   // advance state on a beat, rearm at packet end, reseed on pseudo_sum write while no byte is summed yet
   always_comb begin
      running_sum_in    = running_sum_ff;
      byte_position_in  = byte_position_ff;
      included_count_in = included_count_ff;
      word_half_in      = word_half_ff;
      result.valid        = 1'b0;
      result.checksum     = next_sum ^ SUM_MASK;
      result.summed_bytes = SUM_WIDTH'(next_count);
      if (step) begin
         if (last_byte) begin
            result.valid      = 1'b1;
            running_sum_in    = pseudo_sum_ff;
            byte_position_in  = '0;
            included_count_in = '0;
            word_half_in      = 1'b0;
         end else begin
            running_sum_in    = next_sum;
            included_count_in = next_count;
            word_half_in      = word_half_ff ^ include_byte;
            if (byte_position_ff != {COUNT_WIDTH{1'b1}}) begin
               byte_position_in = byte_position_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end
         end
      end else if (csr_write && (csr_index == CSR_PSEUDO_SUM) &&
                   (included_count_ff == '0)) begin
         running_sum_in = csr_data;
      end
   end

   // hold configuration and packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff   <= '0;
         sum_length_ff     <= '0;
         pseudo_sum_ff     <= '0;
         running_sum_ff    <= '0;
         byte_position_ff  <= '0;
         included_count_ff <= '0;
         word_half_ff      <= 1'b0;
      end else begin
         running_sum_ff    <= running_sum_in;
         byte_position_ff  <= byte_position_in;
         included_count_ff <= included_count_in;
         word_half_ff      <= word_half_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_START_OFFSET: start_offset_ff <= csr_data;
               CSR_SUM_LENGTH:   sum_length_ff   <= csr_data;
               CSR_PSEUDO_SUM:   pseudo_sum_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/ics_out.sv
`default_nettype none

module ics_out import ics_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  result_type                result,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [SUM_WIDTH-1:0]      rsp_checksum,
   output logic [SUM_WIDTH-1:0]      rsp_summed_bytes
);

   logic                 valid_ff, valid_in;
   logic [SUM_WIDTH-1:0] checksum_ff;
   logic [SUM_WIDTH-1:0] summed_bytes_ff;

   // keep a stalled beat, load a new result otherwise
   assign valid_in = result.valid | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         checksum_ff     <= result.checksum;
         summed_bytes_ff <= result.summed_bytes;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_checksum     = checksum_ff;
   assign rsp_summed_bytes = summed_bytes_ff;

endmodule

`default_nettype wire

FILE: design/internet_checksum_byte_stream.sv
// A result appears on rsp in the cycle after the last byte's beat is accepted.
// Throughput: one byte per cycle while req_stall is low; the single end-around add per byte sets the figure.
// Input stalls only while a finished result is held and the result side stalls.
// Reset (synchronous, active high) clears the registers to zero, the running
// sum to zero, and empties the result register; no clearing pass is needed.
`default_nettype none

module internet_checksum_byte_stream import ics_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [BYTE_WIDTH-1:0]    req_data_byte,
   input  wire logic                     req_last_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [SUM_WIDTH-1:0]          rsp_checksum,
   output logic [SUM_WIDTH-1:0]          rsp_summed_bytes,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [SUM_WIDTH-1:0]     csr_data
);

   result_type result;
   logic       step;

   // accept a byte unless a held result is blocked
   assign req_stall = rsp_valid & rsp_stall;
   assign step      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   ics_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   ics_out u_out (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_checksum     (rsp_checksum),
      .rsp_summed_bytes (rsp_summed_bytes)
   );

   // input stall only comes from a held result
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result held");

   // the last byte of a packet always yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_byte) |=> rsp_valid)
      else $error("packet end produced no result");

   // no result appears from a non-final byte
   assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall && req_last_byte) && !(rsp_valid && rsp_stall))
      |=> !rsp_valid)
      else $error("result without packet end");

endmodule

`default_nettype wire

FILE: bench/tb_internet_checksum_byte_stream.sv
`default_nettype none

module tb_internet_checksum_byte_stream;
   import ics_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // index with no register behind it
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NO_REGISTER = 2'd3;
   localparam logic [COUNT_WIDTH-1:0]   COUNT_TOP       = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic [SUM_WIDTH-1:0] checksum;
      logic [SUM_WIDTH-1:0] summed_bytes;
   } sum_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [BYTE_WIDTH-1:0]    req_data_byte = '0;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [SUM_WIDTH-1:0]     rsp_checksum;
   logic [SUM_WIDTH-1:0]     rsp_summed_bytes;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [SUM_WIDTH-1:0]     csr_data = '0;

   // predictor copy of registers and packet state
   logic [SUM_WIDTH-1:0]   cfg_start;
   logic [SUM_WIDTH-1:0]   cfg_length;
   logic [SUM_WIDTH-1:0]   cfg_seed;
   logic [SUM_WIDTH-1:0]   run_sum;
   logic [COUNT_WIDTH-1:0] pos_count;
   logic [COUNT_WIDTH-1:0] incl_count;
   logic                   low_half;

   sum_result_type expected_sums[$];
   sum_result_type head;
   int          failures = 0;
   int          items_sent = 0;
   bit          gaps_on = 1'b1;
   bit          rsp_idling = 1'b1;
   int          hold_off_cycles = 0;

   internet_checksum_byte_stream DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_checksum     (rsp_checksum),
      .rsp_summed_bytes (rsp_summed_bytes),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // reseed the sum and clear the packet counters
   task automatic rearm_packet();
      run_sum    = cfg_seed;
      pos_count  = '0;
      incl_count = '0;
      low_half   = 1'b0;
   endtask

   // advance the predicted checksum by one accepted byte
   task automatic fold_byte(input logic [BYTE_WIDTH-1:0] data, input logic last);
      logic [SUM_WIDTH-1:0] word;
      logic [SUM_WIDTH:0]   raw;
      if (pos_count >= cfg_start && incl_count < cfg_length) begin
         word     = low_half ? {8'h00, data} : {data, 8'h00};
         raw      = {1'b0, run_sum} + {1'b0, word};
         run_sum  = raw[SUM_WIDTH-1:0] + {{(SUM_WIDTH-1){1'b0}}, raw[SUM_WIDTH]};
         low_half = ~low_half;
         if (incl_count != COUNT_TOP)
            incl_count++;
      end
      if (pos_count != COUNT_TOP)
         pos_count++;
      if (last) begin
         expected_sums.push_back('{checksum: ~run_sum,
                                   summed_bytes: incl_count[SUM_WIDTH-1:0]});
         rearm_packet();
      end
   endtask

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one byte and hold it until the beat is taken
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] data, input logic last);
      int gap;
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      fold_byte(data, last);
      items_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, drain every expected result, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register beat on the csr channel
   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [SUM_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_OFFSET: cfg_start = value;
         CSR_SUM_LENGTH:   cfg_length = value;
         CSR_PSEUDO_SUM: begin
            cfg_seed = value;
            if (incl_count == '0)
               run_sum = value;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [SUM_WIDTH-1:0] start, input logic [SUM_WIDTH-1:0] len,
                            input logic [SUM_WIDTH-1:0] seed);
      write_reg(CSR_START_OFFSET, start);
      write_reg(CSR_SUM_LENGTH, len);
      write_reg(CSR_PSEUDO_SUM, seed);
   endtask

   // reset values: nothing summed, seed zero
   task automatic test_reset_defaults();
      send_byte(8'hFF, 1'b1);
      settle();
   endtask

   // all-ones and all-zero bytes, odd trailing byte, all-ones seed
   task automatic test_extremes();
      write_all(16'h0000, 16'hFFFF, 16'h0000);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();
      write_reg(CSR_PSEUDO_SUM, 16'hFFFF);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      settle();
   endtask

   // skip leading bytes and ignore bytes past the length
   task automatic test_window();
      write_all(16'd2, 16'd3, 16'h0000);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h66, 1'b0);
      send_byte(8'h77, 1'b1);
      settle();
      write_all(16'd0, 16'd1, 16'h0000);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b1);
      settle();
   endtask

   // seed write before any summed byte reseeds, after one it waits for the next packet
   task automatic test_seed_write();
      write_all(16'd3, 16'hFFFF, 16'h0000);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      settle();
      write_reg(CSR_PSEUDO_SUM, 16'h1234);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      settle();
      write_reg(CSR_PSEUDO_SUM, 16'hABCD);
      send_byte(8'h05, 1'b1);
      send_byte(8'h06, 1'b1);
      settle();
   endtask

   // write beyond the register list must change nothing
   task automatic test_unknown_register();
      write_all(16'd0, 16'd2, 16'h0000);
      write_reg(CSR_NO_REGISTER, 16'hFFFF);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      settle();
   endtask

   // hold the result side off while bytes keep coming, so input stalls
   task automatic test_back_pressure();
      write_all(16'd0, 16'hFFFF, 16'($urandom));
      gaps_on = 1'b0;
      hold_off_cycles = 200;
      for (int p = 0; p < 5; p++)
         for (int b = 0; b < 10; b++)
            send_byte(8'($urandom_range(0, 255)), b == 9);
      gaps_on = 1'b1;
      settle();
   endtask

   function automatic logic [SUM_WIDTH-1:0] pick_offset();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return 16'($urandom_range(0, 6));
      else if (r < 8)
         return 16'($urandom_range(7, 60));
      else if (r == 8)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [SUM_WIDTH-1:0] pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return 16'($urandom_range(1, 24));
      else if (r < 7)
         return 16'($urandom_range(25, 60));
      else if (r == 7)
         return 16'h0000;
      else if (r == 8)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [SUM_WIDTH-1:0] pick_seed();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_IDX_WIDTH-1:0] pick_index();
      case ($urandom_range(0, 3))
         0:       return CSR_START_OFFSET;
         1:       return CSR_SUM_LENGTH;
         2:       return CSR_PSEUDO_SUM;
         default: return CSR_NO_REGISTER;
      endcase
   endfunction

   // random settings, random packets, now and then a register write mid-packet
   task automatic test_random();
      int start_items;
      int packets;
      int len;
      int cut;
      start_items = items_sent;
      while (items_sent - start_items < 1200) begin
         gaps_on    = $urandom_range(0, 3) != 0;
         rsp_idling = $urandom_range(0, 3) != 0;
         write_all(pick_offset(), pick_length(), pick_seed());
         packets = $urandom_range(3, 6);
         for (int p = 0; p < packets; p++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len + 1;
            for (int b = 0; b < len; b++) begin
               if (b == cut) begin
                  settle();
                  write_reg(pick_index(), ($urandom_range(0, 1) == 1) ? pick_seed()
                                                                      : pick_offset());
               end
               send_byte(8'($urandom_range(0, 255)), b == len - 1);
            end
         end
         settle();
      end
      gaps_on    = 1'b1;
      rsp_idling = 1'b1;
   endtask

   // receiver stall: long hold-off when asked, random bursts otherwise while rsp_idling is set
   initial begin : rsp_side
      int stall_run;
      stall_run = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_run = pick_gap();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $error("result beat with none expected: checksum %h summed_bytes %h",
                   rsp_checksum, rsp_summed_bytes);
            failures++;
         end else begin
            head = expected_sums.pop_front();
            if (rsp_checksum !== head.checksum) begin
               $error("checksum: expected %h, actual %h", head.checksum, rsp_checksum);
               failures++;
            end
            if (rsp_summed_bytes !== head.summed_bytes) begin
               $error("summed_bytes: expected %h, actual %h",
                      head.summed_bytes, rsp_summed_bytes);
               failures++;
            end
         end
      end
   end

   initial begin
      cfg_start  = '0;
      cfg_length = '0;
      cfg_seed   = '0;
      rearm_packet();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      test_window();
      test_seed_write();
      test_unknown_register();
      test_back_pressure();
      test_random();
      settle();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
